// ===== sv/tle_pkg.sv =====
// ============================================================================
// tle_pkg: shared constants and types of the tier latency estimator
// Counter width, word layouts and configuration register indexes used by
// the datapath, the divider and the port checker.
// ============================================================================
package tle_pkg;

    // Width of the free-running hardware counters (32 to 64).
    localparam int CounterBits  = 48;
    // Fixed field widths of the words on the stream ports.
    localparam int InFieldBits  = 48;
    localparam int OutWideBits  = 64;
    localparam int InTdataBits  = 4 * InFieldBits;
    localparam int OutFieldBits = 4 * OutWideBits + 1;
    localparam int OutTdataBits = ((OutFieldBits + 7) / 8) * 8;
    // Divider step counter.
    localparam int DivCntBits   = $clog2(CounterBits);

    // Configuration register port.
    localparam int CfgIndexBits = 2;
    localparam int CfgDataBits  = 32;
    localparam int ShiftBits    = 3;
    localparam int FloorBits    = 16;

    typedef logic [CounterBits-1:0] cnt_t;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_EWMA_SHIFT   = 2'd0,
        CFG_INSERT_THR   = 2'd1,
        CFG_LOCAL_FLOOR  = 2'd2,
        CFG_REMOTE_FLOOR = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [ShiftBits-1:0]   ShiftReset       = 3'd1;
    localparam logic [CfgDataBits-1:0] ThresholdReset   = 32'd2000;
    localparam logic [FloorBits-1:0]   LocalFloorReset  = 16'd280;
    localparam logic [FloorBits-1:0]   RemoteFloorReset = 16'd410;

endpackage

// ===== sv/tle_divider.sv =====
// ============================================================================
// tle_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is ready.
// ============================================================================
module tle_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tle_pkg::cnt_t      dividend,
    input  tle_pkg::cnt_t      divisor,
    output logic               done,
    output tle_pkg::cnt_t      quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [tle_pkg::DivCntBits-1:0]    cnt_reg;
    tle_pkg::cnt_t                     rem_reg;
    tle_pkg::cnt_t                     quo_reg;
    tle_pkg::cnt_t                     dvs_reg;

    logic [tle_pkg::CounterBits:0]     shifted;
    logic [tle_pkg::CounterBits+1:0]   trial;
    logic                              borrow;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[tle_pkg::CounterBits-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        borrow  = trial[tle_pkg::CounterBits+1];
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tle_pkg::DivCntBits'(tle_pkg::CounterBits - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient; the dividend shifts out as the
    // quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? shifted[tle_pkg::CounterBits-1:0]
                              : trial[tle_pkg::CounterBits-1:0];
            quo_reg <= {quo_reg[tle_pkg::CounterBits-2:0], !borrow};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/tier_latency_estimator.sv =====
// ============================================================================
// tier_latency_estimator: two-tier memory latency estimator
// Turns samples of occupancy and insert counters into smoothed per-tier
// latencies by filtering the counter deltas and dividing the results.
// ============================================================================
// Each input word is one sample of four free-running counters. The first
// word after reset only primes the stored counts and produces nothing. Every
// later word produces one result word and occupies the block through the
// four filter updates (delta, difference and apply steps of one shared unit),
// a division per tier in the one-bit-per-cycle divider that both tiers
// share, and the load of the result. A tier whose smoothed inserts do not
// exceed the threshold skips its division. The input stays not ready until
// the result word has been taken.
module tier_latency_estimator (
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0: local_occupancy_count, local_insert_count,
    // remote_occupancy_count, remote_insert_count (48 bits each).
    input  logic [tle_pkg::InTdataBits-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: local_latency (64), remote_latency (64),
    // local_slower (1), local_inserts_smoothed (64),
    // remote_inserts_smoothed (64), zero fill to whole bytes.
    output logic [tle_pkg::OutTdataBits-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [tle_pkg::CfgIndexBits-1:0]    cfg_index,
    input  logic [tle_pkg::CfgDataBits-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIFF,
        ST_APPLY,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_LOAD,
        ST_OUT
    } state_t;

    // Control state.
    state_t                              state_reg, state_next;
    logic [1:0]                          ch_reg, ch_next;
    logic                                tier_reg, tier_next;
    logic                                primed_reg, primed_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    // Filter state, in input order: local occupancy, local inserts,
    // remote occupancy, remote inserts.
    tle_pkg::cnt_t                       smooth_reg [4];
    tle_pkg::cnt_t                       smooth_next [4];
    // Working registers.
    tle_pkg::cnt_t                       cur_reg [4];
    tle_pkg::cnt_t                       cur_next [4];
    tle_pkg::cnt_t                       prev_reg [4];
    tle_pkg::cnt_t                       prev_next [4];
    tle_pkg::cnt_t                       delta_reg, delta_next;
    tle_pkg::cnt_t                       diff_reg, diff_next;
    logic                                ge_reg, ge_next;
    tle_pkg::cnt_t                       lat_reg [2];
    tle_pkg::cnt_t                       lat_next [2];
    logic [tle_pkg::OutTdataBits-1:0]    m_tdata_reg, m_tdata_next;
    // Configuration registers.
    logic [tle_pkg::ShiftBits-1:0]       ewma_shift_reg;
    logic [tle_pkg::CfgDataBits-1:0]     insert_threshold_reg;
    logic [tle_pkg::FloorBits-1:0]       floor_reg [2];

    // Shared filter unit and divider hookup.
    tle_pkg::cnt_t                       old_value;
    tle_pkg::cnt_t                       shifted_diff;
    tle_pkg::cnt_t                       low_bits;
    logic                                round_up;
    tle_pkg::cnt_t                       filtered;
    tle_pkg::cnt_t                       tier_occ;
    tle_pkg::cnt_t                       tier_ins;
    tle_pkg::cnt_t                       tier_floor;
    logic                                div_start;
    logic                                div_done;
    tle_pkg::cnt_t                       div_quotient;

    tle_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tier_occ),
        .divisor  (tier_ins),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Filter step: move the old value toward the delta by diff >> shift,
    // rounding the step up when moving downward.
    always_comb
    begin
        old_value    = smooth_reg[ch_reg];
        shifted_diff = diff_reg >> ewma_shift_reg;
        low_bits     = diff_reg & ~({tle_pkg::CounterBits{1'b1}} << ewma_shift_reg);
        round_up     = !ge_reg && (low_bits != '0);
        filtered     = ge_reg ? (old_value + shifted_diff)
                              : (old_value - shifted_diff
                                 - tle_pkg::CounterBits'(round_up));
    end

    // Operands of the tier being resolved.
    always_comb
    begin
        tier_occ   = smooth_reg[{tier_reg, 1'b0}];
        tier_ins   = smooth_reg[{tier_reg, 1'b1}];
        tier_floor = tle_pkg::CounterBits'(floor_reg[tier_reg]);
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        tier_next     = tier_reg;
        primed_next   = primed_reg;
        m_tvalid_next = m_tvalid_reg;
        smooth_next   = smooth_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        delta_next    = delta_reg;
        diff_next     = diff_reg;
        ge_next       = ge_reg;
        lat_next      = lat_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        cur_next[i] = tle_pkg::CounterBits'(
                            s_tdata[i*tle_pkg::InFieldBits +: tle_pkg::InFieldBits]);
                        if (!primed_reg)
                        begin
                            prev_next[i] = cur_next[i];
                        end
                    end
                    if (primed_reg)
                    begin
                        ch_next    = 2'd0;
                        state_next = ST_DELTA;
                    end
                    else
                    begin
                        primed_next = 1'b1;
                    end
                end
            end

            ST_DELTA:
            begin
                // Wraps naturally at the counter width.
                delta_next        = cur_reg[ch_reg] - prev_reg[ch_reg];
                prev_next[ch_reg] = cur_reg[ch_reg];
                state_next        = ST_DIFF;
            end

            ST_DIFF:
            begin
                ge_next    = delta_reg >= old_value;
                diff_next  = (delta_reg >= old_value) ? (delta_reg - old_value)
                                                      : (old_value - delta_reg);
                state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                smooth_next[ch_reg] = filtered;
                if (ch_reg == 2'd3)
                begin
                    tier_next  = 1'b0;
                    state_next = ST_DIV_START;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_DELTA;
                end
            end

            ST_DIV_START:
            begin
                if (64'(tier_ins) > 64'(insert_threshold_reg))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    lat_next[tier_reg] = tier_floor;
                    if (tier_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        tier_next = 1'b1;
                    end
                end
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    lat_next[tier_reg] = (div_quotient > tier_floor) ? div_quotient
                                                                     : tier_floor;
                    if (tier_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        tier_next  = 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end

            ST_LOAD:
            begin
                m_tdata_next = tle_pkg::OutTdataBits'({
                    64'(smooth_reg[3]),
                    64'(smooth_reg[1]),
                    (lat_reg[0] > lat_reg[1]),
                    64'(lat_reg[1]),
                    64'(lat_reg[0])});
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, filter state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            ch_reg               <= 2'd0;
            tier_reg             <= 1'b0;
            primed_reg           <= 1'b0;
            m_tvalid_reg         <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                smooth_reg[i] <= '0;
            end
            ewma_shift_reg       <= tle_pkg::ShiftReset;
            insert_threshold_reg <= tle_pkg::ThresholdReset;
            floor_reg[0]         <= tle_pkg::LocalFloorReset;
            floor_reg[1]         <= tle_pkg::RemoteFloorReset;
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            tier_reg     <= tier_next;
            primed_reg   <= primed_next;
            m_tvalid_reg <= m_tvalid_next;
            smooth_reg   <= smooth_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tle_pkg::CFG_EWMA_SHIFT:
                        ewma_shift_reg <= cfg_wdata[tle_pkg::ShiftBits-1:0];
                    tle_pkg::CFG_INSERT_THR:
                        insert_threshold_reg <= cfg_wdata;
                    tle_pkg::CFG_LOCAL_FLOOR:
                        floor_reg[0] <= cfg_wdata[tle_pkg::FloorBits-1:0];
                    tle_pkg::CFG_REMOTE_FLOOR:
                        floor_reg[1] <= cfg_wdata[tle_pkg::FloorBits-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        delta_reg   <= delta_next;
        diff_reg    <= diff_next;
        ge_reg      <= ge_next;
        lat_reg     <= lat_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/tle_checker.sv =====
// ============================================================================
// tle_checker: port checks for the tier latency estimator
// Watches the stream ports over time and flags misbehavior.
// ============================================================================
module tle_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tle_pkg::OutTdataBits-1:0]    m_tdata
);

    // A pending result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

    // The block never takes a new word while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

    // A result word is shown only once: valid drops after it has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
    else $error("result word repeated");

    // The slower flag agrees with the two latencies it summarizes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[128] == (m_tdata[63:0] > m_tdata[127:64])))
    else $error("local_slower disagrees with the latencies");

endmodule

bind tier_latency_estimator tle_checker u_tle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
